### hw/rtl/comma_list_number_parser_assert.svh
// Assertion macros shared by the checker of the comma list number parser.
// Needs a clock named clk and an active-high reset named rst in the using scope.
`ifndef COMMA_LIST_NUMBER_PARSER_ASSERT_SVH
`define COMMA_LIST_NUMBER_PARSER_ASSERT_SVH

// Checked at every edge outside of reset.
`define CLNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CLNP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/clnp_pkg.sv
// Package of the comma list number parser: widths, character codes, op word type.
// No dependencies; every other file of the block but the assertion header imports it.
`default_nettype none

package clnp_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACC_W = VAL_W + 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CH_W-1:0] CH_LOW_X = 8'h78;
  localparam logic [CH_W-1:0] CH_UP_X = 8'h58;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB = 8'h09;
  localparam logic [CH_W-1:0] CH_CR = 8'h0D;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;
  localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_F = 8'h66;
  localparam logic [CH_W-1:0] CH_UP_A = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_F = 8'h46;

  // accumulator clamp point (2^31) and the two saturated results
  localparam logic [VAL_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

  // one classified character, front to back
  typedef struct packed {
    logic       keep;     // not blank, not comma
    logic       comma;
    logic       last;
    logic       is_minus;
    logic       is_plus;
    logic       is_x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;    // hex value, valid when hex_ok
  } clnp_op_t;

  typedef enum logic {
    PH_ACTION,
    PH_FINAL
  } clnp_phase_t;

endpackage

`default_nettype wire

### hw/rtl/clnp_char_if.sv
// Character channel of the comma list number parser (valid/ready word plus payload).
// Depends on clnp_pkg for the character width.
`default_nettype none

interface clnp_char_if import clnp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/clnp_num_if.sv
// Number channel of the comma list number parser (valid/ready word plus payload).
// Depends on clnp_pkg for the value width.
`default_nettype none

interface clnp_num_if import clnp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             saturated;
  logic             final_number;

  modport source (output valid, output value, output saturated, output final_number,
                  input ready);
  modport sink (input valid, input value, input saturated, input final_number,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/clnp_front.sv
// Front end: takes character words and classifies each into an op word.
// Depends on clnp_pkg and clnp_char_if.
`default_nettype none

module clnp_front import clnp_pkg::*; (
  clnp_char_if.sink  chars,
  output logic       push_valid,
  input  logic       push_ready,
  output clnp_op_t   push_op
);

  logic blank;
  logic comma;
  logic is_dec;
  logic is_low;
  logic is_up;

  always_comb begin
    blank  = chars.ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    comma  = (chars.ch == CH_COMMA);
    is_dec = chars.ch inside {[CH_ZERO:CH_NINE]};
    is_low = chars.ch inside {[CH_LOW_A:CH_LOW_F]};
    is_up  = chars.ch inside {[CH_UP_A:CH_UP_F]};
  end

  always_comb begin
    push_op.keep     = !blank && !comma;
    push_op.comma    = comma;
    push_op.last     = chars.last;
    push_op.is_minus = (chars.ch == CH_MINUS);
    push_op.is_plus  = (chars.ch == CH_PLUS);
    push_op.is_x     = (chars.ch == CH_LOW_X) || (chars.ch == CH_UP_X);
    push_op.dec_ok   = is_dec;
    push_op.hex_ok   = is_dec || is_low || is_up;
    // letters: low nibble of 'a'/'A' is 1, so +9 gives 10
    push_op.digit    = is_dec ? chars.ch[3:0] : chars.ch[3:0] + 4'd9;
  end

  assign push_valid  = chars.valid;
  assign chars.ready = push_ready;

endmodule

`default_nettype wire

### hw/rtl/clnp_queue.sv
// Small op queue between front and back; flop storage, push and pop in the same cycle.
// Depends on clnp_pkg for the op word type.
`default_nettype none

module clnp_queue import clnp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  clnp_op_t push_op,
  output logic     pop_valid,
  input  logic     pop_ready,
  output clnp_op_t pop_op
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  clnp_op_t         slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PTR_LAST) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/clnp_back.sv
// Back end: token state, strtol-style accumulate and clamp, registered number output.
// Depends on clnp_pkg and clnp_num_if.
`default_nettype none

module clnp_back import clnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  output logic       op_ready,
  input  clnp_op_t   op,
  clnp_num_if.source numbers
);

  clnp_phase_t      phase;
  clnp_phase_t      phase_next;

  logic [1:0]       kept_count;
  logic             negative;
  logic [VAL_W-1:0] dec_mag;
  logic             dec_stopped;
  logic [VAL_W-1:0] hex_mag;
  logic             hex_stopped;
  logic             hex_mode;
  logic             over_limit;
  logic             first_hex_ok;
  logic [3:0]       first_digit;
  logic             first_zero;

  logic [1:0]       kept_count_next;
  logic             negative_next;
  logic [VAL_W-1:0] dec_mag_next;
  logic             dec_stopped_next;
  logic [VAL_W-1:0] hex_mag_next;
  logic             hex_stopped_next;
  logic             hex_mode_next;
  logic             over_limit_next;
  logic             first_hex_ok_next;
  logic [3:0]       first_digit_next;
  logic             first_zero_next;

  logic             out_valid;
  logic [VAL_W-1:0] out_value;
  logic             out_sat;
  logic             out_fin;

  logic             out_free;
  logic             do_act;
  logic             emit_comma;
  logic             do_final;
  logic             load_out;

  logic [ACC_W-1:0] dec_acc;
  logic [ACC_W-1:0] hex_acc;
  logic             dec_over;
  logic             hex_over;
  logic [VAL_W-1:0] emit_value;
  logic             emit_sat;

  assign out_free = !out_valid || numbers.ready;

  // phase: PH_FINAL emits the number closed by the last character
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_ACTION: begin
        if (do_act && op.last) begin
          phase_next = PH_FINAL;
        end
      end
      PH_FINAL: begin
        if (out_free) begin
          phase_next = PH_ACTION;
        end
      end
      default: phase_next = PH_ACTION;
    endcase
  end

  always_comb begin
    do_act   = 1'b0;
    do_final = 1'b0;
    case (phase)
      PH_ACTION: do_act   = op_valid && (!op.comma || out_free);
      PH_FINAL:  do_final = out_free;
      default: ;
    endcase
    emit_comma = do_act && op.comma;
    load_out   = emit_comma || do_final;
    op_ready   = (do_act && !op.last) || do_final;
  end

  // value*base + digit, clamped at 2^31
  always_comb begin
    dec_acc  = {1'b0, dec_mag, 3'b000} + {3'b000, dec_mag, 1'b0} + {32'd0, op.digit};
    hex_acc  = {hex_mag, 4'b0000} | {32'd0, op.digit};
    dec_over = dec_acc > {4'd0, MAG_CAP};
    hex_over = hex_acc > {4'd0, MAG_CAP};
  end

  always_comb begin
    kept_count_next   = kept_count;
    negative_next     = negative;
    dec_mag_next      = dec_mag;
    dec_stopped_next  = dec_stopped;
    hex_mag_next      = hex_mag;
    hex_stopped_next  = hex_stopped;
    hex_mode_next     = hex_mode;
    over_limit_next   = over_limit;
    first_hex_ok_next = first_hex_ok;
    first_digit_next  = first_digit;
    first_zero_next   = first_zero;
    if (load_out) begin
      kept_count_next   = '0;
      negative_next     = 1'b0;
      dec_mag_next      = '0;
      dec_stopped_next  = 1'b0;
      hex_mag_next      = '0;
      hex_stopped_next  = 1'b0;
      hex_mode_next     = 1'b0;
      over_limit_next   = 1'b0;
      first_hex_ok_next = 1'b0;
      first_digit_next  = '0;
      first_zero_next   = 1'b0;
    end else if (do_act && op.keep) begin
      // decimal digit step unless sign/x handling below applies
      if ((kept_count == 2'd0 && !op.is_minus && !op.is_plus) ||
          (kept_count == 2'd1 && !op.is_x) ||
          (kept_count == 2'd2 && !hex_mode)) begin
        if (!dec_stopped) begin
          if (!op.dec_ok) begin
            dec_stopped_next = 1'b1;
          end else if (dec_over) begin
            dec_mag_next    = MAG_CAP;
            over_limit_next = 1'b1;
          end else begin
            dec_mag_next = dec_acc[VAL_W-1:0];
          end
        end
      end
      case (kept_count)
        2'd0: begin
          first_hex_ok_next = op.hex_ok;
          first_digit_next  = op.digit;
          first_zero_next   = op.dec_ok && (op.digit == 4'd0);
          negative_next     = op.is_minus;
          kept_count_next   = 2'd1;
        end
        2'd1: begin
          if (op.is_x) begin
            hex_mode_next    = 1'b1;
            hex_mag_next     = first_hex_ok ? {28'd0, first_digit} : '0;
            hex_stopped_next = !first_zero;
          end
          kept_count_next = 2'd2;
        end
        default: begin
          if (hex_mode && !hex_stopped) begin
            if (!op.hex_ok) begin
              hex_stopped_next = 1'b1;
            end else if (hex_over) begin
              hex_mag_next    = MAG_CAP;
              over_limit_next = 1'b1;
            end else begin
              hex_mag_next = hex_acc[VAL_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // number of the current token; magnitudes never exceed 2^31
  always_comb begin
    if (hex_mode) begin
      emit_sat   = over_limit || hex_mag[VAL_W-1];
      emit_value = emit_sat ? SAT_POS : hex_mag;
    end else if (negative) begin
      emit_sat   = over_limit;
      emit_value = emit_sat ? SAT_NEG : '0 - dec_mag;
    end else begin
      emit_sat   = over_limit || dec_mag[VAL_W-1];
      emit_value = emit_sat ? SAT_POS : dec_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ACTION;
      kept_count   <= '0;
      negative     <= 1'b0;
      dec_mag      <= '0;
      dec_stopped  <= 1'b0;
      hex_mag      <= '0;
      hex_stopped  <= 1'b0;
      hex_mode     <= 1'b0;
      over_limit   <= 1'b0;
      first_hex_ok <= 1'b0;
      first_digit  <= '0;
      first_zero   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      kept_count   <= kept_count_next;
      negative     <= negative_next;
      dec_mag      <= dec_mag_next;
      dec_stopped  <= dec_stopped_next;
      hex_mag      <= hex_mag_next;
      hex_stopped  <= hex_stopped_next;
      hex_mode     <= hex_mode_next;
      over_limit   <= over_limit_next;
      first_hex_ok <= first_hex_ok_next;
      first_digit  <= first_digit_next;
      first_zero   <= first_zero_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (numbers.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= emit_value;
      out_sat   <= emit_sat;
      out_fin   <= do_final;
    end
  end

  assign numbers.valid        = out_valid;
  assign numbers.value        = out_value;
  assign numbers.saturated    = out_sat;
  assign numbers.final_number = out_fin;

endmodule

`default_nettype wire

### hw/rtl/comma_list_number_parser.sv
// Top level of the comma list number parser: front, op queue and back end.
// Depends on clnp_pkg, clnp_char_if, clnp_num_if, clnp_front, clnp_queue, clnp_back.
//
//   channel   dir  payload                                  word accepted when
//   chars     in   ch[7:0], last                            valid && ready
//   numbers   out  value[31:0], saturated, final_number     valid && ready
//
// Cycles: one character word a cycle while the queue has room; a word with last set
//   stays queued while the back end passes PH_FINAL, where its number is emitted.
// Path: a comma word that closes a number passes a queue slot, then the output
//   register, before numbers.valid rises; a number closed by last also passes the
//   back end's PH_FINAL state between the two.
// Reset: rst synchronous, clears the queue, token state and output valid.
// Stalls: the queue lets chars keep flowing while numbers is held; chars.ready
//   drops only with the queue full.
`default_nettype none

module comma_list_number_parser import clnp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  clnp_char_if.sink  chars,
  clnp_num_if.source numbers
);

  // front to queue
  logic     push_valid;
  logic     push_ready;
  clnp_op_t push_op;

  // queue to back end
  logic     pop_valid;
  logic     pop_ready;
  clnp_op_t pop_op;

  // classify: blank, comma, sign, x, digit value in both bases
  clnp_front u_front (
    .chars      (chars),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // decouples character intake from number delivery
  clnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // token accumulate, clamp and the registered number output
  clnp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (pop_valid),
    .op_ready (pop_ready),
    .op       (pop_op),
    .numbers  (numbers)
  );

endmodule

`default_nettype wire

### hw/rtl/clnp_checker.sv
// Port-level checker of the comma list number parser, bound to the top level.
// Depends on clnp_pkg and comma_list_number_parser_assert.svh.
`default_nettype none

`include "comma_list_number_parser_assert.svh"

module clnp_checker import clnp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_value,
  input logic             out_saturated,
  input logic             out_final
);

  logic [7:0] last_open;
  logic       last_in;
  logic       final_out;
  logic       sat_pattern;

  assign last_in     = in_valid && in_ready && in_last;
  assign final_out   = out_valid && out_ready && out_final;
  assign sat_pattern = (out_value == SAT_POS) || (out_value == SAT_NEG);

  // strings whose closing number is still owed
  always_ff @(posedge clk) begin
    if (rst) begin
      last_open <= '0;
    end else if (last_in && !final_out) begin
      last_open <= last_open + 1'b1;
    end else if (final_out && !last_in) begin
      last_open <= last_open - 1'b1;
    end
  end

  `CLNP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "number word dropped")
  `CLNP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_value), "value moved")
  `CLNP_ASSERT(a_sat_limits, out_valid && out_saturated |-> sat_pattern, "bad clamp")
  `CLNP_ASSERT(a_final_owed, final_out |-> last_open != 8'd0, "final number without last")
  `CLNP_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !out_valid, "output after reset")

endmodule

bind comma_list_number_parser clnp_checker u_clnp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (chars.valid),
  .in_ready      (chars.ready),
  .in_last       (chars.last),
  .out_valid     (numbers.valid),
  .out_ready     (numbers.ready),
  .out_value     (numbers.value),
  .out_saturated (numbers.saturated),
  .out_final     (numbers.final_number)
);

`default_nettype wire

### dv/clnp_list_checker.sv
// Checker for the comma list number parser: watches both channels, predicts numbers.
// Depends on clnp_pkg, clnp_char_if and clnp_num_if.
`timescale 1ns / 1ps

module clnp_list_checker import clnp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  clnp_char_if        chars,
  clnp_num_if         numbers,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [1:0]       kept;
    logic [CH_W-1:0]  first;
    logic             neg;
    logic [VAL_W-1:0] dec_mag;
    logic             dec_stop;
    logic [VAL_W-1:0] hex_mag;
    logic             hex_stop;
    logic             hex_mode;
    logic             over;
  } token_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             saturated;
    logic             final_number;
  } number_t;

  token_t      tok;
  number_t     expected_numbers[$];
  number_t     want;
  int unsigned errors = 0;

  // -1 when c is not a digit of the radix
  function automatic int digit_value(logic [CH_W-1:0] c, int radix);
    int d;
    d = -1;
    if (c >= CH_ZERO && c <= CH_NINE) d = int'(c - CH_ZERO);
    else if (c >= CH_LOW_A && c <= CH_LOW_F) d = int'(c - CH_LOW_A) + 10;
    else if (c >= CH_UP_A && c <= CH_UP_F) d = int'(c - CH_UP_A) + 10;
    if (d >= radix) d = -1;
    return d;
  endfunction

  // magnitude * radix + d, clamped at 2^31
  function automatic logic [VAL_W-1:0] scaled_add(logic [VAL_W-1:0] mag, int radix, int d);
    logic [63:0] n;
    n = {32'b0, mag} * 64'(radix) + 64'(d);
    if (n > {32'b0, MAG_CAP}) begin
      tok.over = 1'b1;
      return MAG_CAP;
    end
    return n[VAL_W-1:0];
  endfunction

  function automatic void dec_digit(logic [CH_W-1:0] c);
    int d;
    if (!tok.dec_stop) begin
      d = digit_value(c, 10);
      if (d < 0) tok.dec_stop = 1'b1;
      else tok.dec_mag = scaled_add(tok.dec_mag, 10, d);
    end
  endfunction

  function automatic void close_token(logic fin);
    number_t n;
    if (tok.hex_mode) begin
      n.saturated = tok.over || tok.hex_mag > SAT_POS;
      n.value = n.saturated ? SAT_POS : tok.hex_mag;
    end else if (tok.neg) begin
      n.saturated = tok.over;
      n.value = n.saturated ? SAT_NEG : -tok.dec_mag;
    end else begin
      n.saturated = tok.over || tok.dec_mag > SAT_POS;
      n.value = n.saturated ? SAT_POS : tok.dec_mag;
    end
    n.final_number = fin;
    expected_numbers.push_back(n);
    tok = '0;
  endfunction

  function automatic void parse_char(logic [CH_W-1:0] c, logic fin);
    int d;
    if (c == CH_COMMA) begin
      close_token(1'b0);
    end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      case (tok.kept)
        2'd0: begin
          tok.first = c;
          if (c == CH_MINUS) tok.neg = 1'b1;
          else if (c != CH_PLUS) dec_digit(c);
          tok.kept = 2'd1;
        end
        2'd1: begin
          if (c == CH_LOW_X || c == CH_UP_X) begin
            // only "0x" keeps converting; any other lead leaves at most its own digit
            d = digit_value(tok.first, 16);
            tok.hex_mode = 1'b1;
            tok.hex_mag = (d < 0) ? '0 : VAL_W'(d);
            tok.hex_stop = (tok.first != CH_ZERO);
          end else begin
            dec_digit(c);
          end
          tok.kept = 2'd2;
        end
        default: begin
          if (!tok.hex_mode) begin
            dec_digit(c);
          end else if (!tok.hex_stop) begin
            d = digit_value(c, 16);
            if (d < 0) tok.hex_stop = 1'b1;
            else tok.hex_mag = scaled_add(tok.hex_mag, 16, d);
          end
        end
      endcase
    end
    if (fin) close_token(1'b1);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tok = '0;
      expected_numbers.delete();
    end else begin
      if (chars.valid && chars.ready) parse_char(chars.ch, chars.last);
      if (numbers.valid && numbers.ready) begin
        if (expected_numbers.size() == 0) begin
          $error("number word 0x%08h with no number expected", numbers.value);
          errors++;
        end else begin
          want = expected_numbers.pop_front();
          if (numbers.value !== want.value) begin
            $error("value: expected 0x%08h, got 0x%08h", want.value, numbers.value);
            errors++;
          end
          if (numbers.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, numbers.saturated);
            errors++;
          end
          if (numbers.final_number !== want.final_number) begin
            $error("final_number: expected %b, got %b", want.final_number,
                   numbers.final_number);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    outstanding <= expected_numbers.size();
  end

endmodule

### dv/tb_comma_list_number_parser.sv
// Testbench top of the comma list number parser: clock, reset, character stimulus,
// number sink and verdict. Depends on clnp_pkg, both channel interfaces and clnp_list_checker.
`timescale 1ns / 1ps

module tb_comma_list_number_parser import clnp_pkg::*;;

  logic        clk = 1'b0;
  logic        rst;
  logic        stall_request;
  int unsigned mismatches;
  int unsigned outstanding;

  // sender burst bookkeeping and count of non-blank words sent
  int          burst_left;
  int unsigned kept_sent;

  // string under construction, one character per word
  logic [CH_W-1:0] text[$];

  // tokens at and past the signed 32-bit limits
  string limit_tokens[8] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                             "0x7FFFFFFF", "0x80000000", "0XffffFFFF", "4294967296"};

  clnp_char_if chars();
  clnp_num_if  numbers();

  comma_list_number_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .numbers (numbers)
  );

  clnp_list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .numbers     (numbers),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Number sink: ready follows a randomly drawn mode, redrawn after a random run
  // (always ready, mostly ready, mostly stalled). Once stall_request is seen,
  // ready is held low for a long stretch so the op queue fills and chars.ready drops.
  initial begin : number_sink
    int   mode;
    int   mode_left;
    logic stall_served;
    mode = 0;
    mode_left = 0;
    stall_served = 1'b0;
    numbers.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_served) begin
        stall_served = 1'b1;
        numbers.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0: numbers.ready <= 1'b1;
          1: numbers.ready <= ($urandom_range(0, 3) != 0);
          default: numbers.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one character word and return at the edge that accepts it. Words go
  // out in bursts; between bursts valid drops for a random gap (often none).
  task automatic push_char(input logic [CH_W-1:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        chars.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    chars.valid <= 1'b1;
    chars.ch <= c;
    chars.last <= fin;
    do @(posedge clk); while (!chars.ready);
    if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) kept_sent++;
  endtask

  // send the built string, last set on its final character
  task automatic send_text();
    foreach (text[i]) push_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  // append a character, sometimes after a blank (space, tab .. carriage return)
  task automatic add_char(logic [CH_W-1:0] c);
    if ($urandom_range(0, 7) == 0)
      text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB + CH_W'($urandom_range(0, 4)));
    text.push_back(c);
  endtask

  function automatic logic [CH_W-1:0] hex_digit(int d);
    if (d < 10) return CH_ZERO + CH_W'(d);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + CH_W'(d - 10);
  endfunction

  // one token of a list; mostly well-formed numbers, the rest odd or noise
  task automatic add_token();
    int    n;
    string s;
    case ($urandom_range(0, 9))
      0: ; // empty token
      1, 2, 3: begin
        // decimal, optional sign; a quarter of them long (9 to 12 digits), which can overflow
        n = $urandom_range(0, 2);
        if (n == 1) add_char(CH_MINUS);
        else if (n == 2) add_char(CH_PLUS);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
        repeat (n) add_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
      end
      4, 5: begin
        // hex, possibly with no digits after the prefix
        add_char(CH_ZERO);
        add_char($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
        repeat ($urandom_range(0, 10)) add_char(hex_digit($urandom_range(0, 15)));
      end
      6: begin
        s = limit_tokens[$urandom_range(0, 7)];
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
      end
      7: begin
        // raw bytes over the whole range, NUL and high half included
        repeat ($urandom_range(1, 4)) add_char(CH_W'($urandom_range(0, 255)));
      end
      8: begin
        // digits cut off by a stray byte
        repeat ($urandom_range(1, 3)) add_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
        add_char(CH_W'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) add_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
      end
      default: begin
        // something other than 0 ahead of the x
        case ($urandom_range(0, 4))
          0: add_char(CH_MINUS);
          1: add_char(CH_PLUS);
          2: add_char(CH_LOW_X);
          3: add_char(CH_ZERO + CH_W'($urandom_range(1, 9)));
          default: add_char(hex_digit($urandom_range(10, 15)));
        endcase
        add_char($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
        repeat ($urandom_range(0, 4)) add_char(hex_digit($urandom_range(0, 15)));
      end
    endcase
  endtask

  initial begin
    rst <= 1'b1;
    chars.valid <= 1'b0;
    chars.ch <= '0;
    chars.last <= 1'b0;
    stall_request <= 1'b0;
    burst_left = 0;
    kept_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: leading/empty tokens, lone sign, sign before x, digit before x,
    // bare 0x, trailing comma ending on last; then the exact minimum and a
    // negative overflow; then NUL and a high byte as the whole string.
    add_str(",-,-x5,5x1,0x,");
    send_text();
    add_str("-2147483648,-4294967296");
    send_text();
    text.push_back(8'h00);
    text.push_back(8'hFF);
    send_text();

    // sender pause: hold off until every number so far has come back
    chars.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);

    // long sink stall against a run of commas: one number per word fills the queue
    stall_request <= 1'b1;
    repeat (24) text.push_back(CH_COMMA);
    add_str("7");
    send_text();

    // random lists of 1..6 tokens, sometimes a trailing comma or a trailing blank
    while (kept_sent < 750) begin
      for (int k = $urandom_range(1, 6); k > 0; k--) begin
        add_token();
        if (k > 1) add_char(CH_COMMA);
      end
      if ($urandom_range(0, 4) == 0) add_char(CH_COMMA);
      if ($urandom_range(0, 5) == 0) text.push_back(CH_SPACE);
      send_text();
    end

    // drain, then keep watching to catch stray numbers
    chars.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
